### rtl/core/vmeu_pkg.sv
// Shared types, opcodes and stream layout constants for the VM execute unit.
package vmeu_pkg;

  // Default sizes of the register file, data path and stack store
  localparam int NUM_REGS_DEF    = 32;
  localparam int WORD_BITS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 256;

  // Input stream layout (tdata); kind travels on tuser
  localparam int OPC_LSB    = 0;
  localparam int DST_LSB    = 6;
  localparam int SRCA_LSB   = 11;
  localparam int SRCB_LSB   = 16;
  localparam int DATA_LSB   = 21;
  localparam int IN_TDATA_W = 88;

  // Output stream layout (tdata)
  localparam int PC_LSB      = 0;
  localparam int FN_BIT      = 64;
  localparam int FZ_BIT      = 65;
  localparam int FC_BIT      = 66;
  localparam int FV_BIT      = 67;
  localparam int HALT_BIT    = 68;
  localparam int ERR_LSB     = 69;
  localparam int OUT_TDATA_W = 72;

  // Transfer kinds on the input tuser
  localparam logic KIND_START = 1'b0;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_UNF  = 2'd3;

  // Opcodes in dispatch order
  localparam logic [5:0] OP_EXT  = 6'd0;
  localparam logic [5:0] OP_ASR  = 6'd1;
  localparam logic [5:0] OP_MOV  = 6'd3;
  localparam logic [5:0] OP_ADD  = 6'd4;
  localparam logic [5:0] OP_ADDS = 6'd5;
  localparam logic [5:0] OP_ADC  = 6'd6;
  localparam logic [5:0] OP_AND  = 6'd7;
  localparam logic [5:0] OP_BIC  = 6'd8;
  localparam logic [5:0] OP_CLZ  = 6'd9;
  localparam logic [5:0] OP_CMN  = 6'd10;
  localparam logic [5:0] OP_EOR  = 6'd11;
  localparam logic [5:0] OP_SUB  = 6'd12;
  localparam logic [5:0] OP_SUBS = 6'd13;
  localparam logic [5:0] OP_SBC  = 6'd14;
  localparam logic [5:0] OP_MUL  = 6'd15;
  localparam logic [5:0] OP_MLS  = 6'd16;
  localparam logic [5:0] OP_MULS = 6'd17;
  localparam logic [5:0] OP_NOT  = 6'd18;
  localparam logic [5:0] OP_DIV  = 6'd19;
  localparam logic [5:0] OP_DVS  = 6'd20;
  localparam logic [5:0] OP_DIVS = 6'd21;
  localparam logic [5:0] OP_BL   = 6'd22;
  localparam logic [5:0] OP_B    = 6'd23;
  localparam logic [5:0] OP_LSL  = 6'd30;
  localparam logic [5:0] OP_LSR  = 6'd31;
  localparam logic [5:0] OP_ORR  = 6'd34;
  localparam logic [5:0] OP_PUSH = 6'd35;
  localparam logic [5:0] OP_POP  = 6'd36;
  localparam logic [5:0] OP_CMP  = 6'd37;
  localparam logic [5:0] OP_NOP  = 6'd38;
  localparam logic [5:0] OP_BEQ  = 6'd39;
  localparam logic [5:0] OP_BNEQ = 6'd40;
  localparam logic [5:0] OP_BLEQ = 6'd41;
  localparam logic [5:0] OP_BGEQ = 6'd42;
  localparam logic [5:0] OP_BLES = 6'd43;
  localparam logic [5:0] OP_BGRE = 6'd44;
  localparam logic [5:0] OP_RET  = 6'd45;
  localparam logic [5:0] OP_ROR  = 6'd46;
  localparam logic [5:0] OP_TST  = 6'd49;
  localparam logic [5:0] OP_TEQ  = 6'd50;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_ITER,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

### rtl/core/vm_execute_unit_with_flags_core.sv
// Flow: a start transfer goes from acceptance straight to output; simple ops pass through accept,
//   operand read, execute and output; clz, mul and div also iterate in the shared shift/add
//   unit, as does ror when WORD_BITS is not a power of two. One item at a time; the next
//   transfer is taken once the result moves into the output register.
// Reset: flags, PC/LR/SP/DA and register file valid bits cleared at once; the stack
//   store is not cleared.
module vm_execute_unit_with_flags_core #(
  parameter int NUM_REGS    = vmeu_pkg::NUM_REGS_DEF,
  parameter int WORD_BITS   = vmeu_pkg::WORD_BITS_DEF,
  parameter int STACK_DEPTH = vmeu_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[5:0], dest_reg[10:6], src_a_reg[15:11], src_b_reg[20:16], data_word[84:21]
  input  logic [vmeu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // next_pc[63:0], flag_n[64], flag_z[65], flag_c[66], flag_v[67], halted[68],
  // error_code[70:69]
  output logic [vmeu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import vmeu_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int RIW  = $clog2(NUM_REGS);
  localparam int SIW  = $clog2(STACK_DEPTH);
  localparam int SHW  = $clog2(WORD_BITS);
  localparam int CLZW = $clog2(WORD_BITS + 1);
  localparam int CMPW = (WORD_BITS > 17) ? WORD_BITS : 17;
  localparam bit W_POW2 = ((WORD_BITS & (WORD_BITS - 1)) == 0);

  localparam logic [RIW-1:0]  R_DA = RIW'(NUM_REGS - 1);
  localparam logic [RIW-1:0]  R_PC = RIW'(NUM_REGS - 2);
  localparam logic [RIW-1:0]  R_LR = RIW'(NUM_REGS - 3);
  localparam logic [RIW-1:0]  R_SP = RIW'(NUM_REGS - 4);
  localparam logic [W-1:0]    W_C  = W'(WORD_BITS);
  localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(STACK_DEPTH);
  localparam logic [CMPW-1:0] DEPTH_M1 = CMPW'(STACK_DEPTH - 1);

  // Register index modulo the register file size; exact for NUM_REGS of 7 or more
  function automatic logic [RIW-1:0] reg_idx(input logic [4:0] raw);
    logic [4:0] v;
    v = raw;
    for (int i = 0; i < 4; i++) begin
      if (32'(v) >= NUM_REGS) begin
        v = v - 5'(NUM_REGS);
      end
    end
    return RIW'(v);
  endfunction

  // Logic-op flags: C and V cleared, N and Z from the result
  function automatic logic [3:0] lflags(input logic [W-1:0] r);
    return {r[W-1], (r == '0), 1'b0, 1'b0};
  endfunction

  state_e state_q, state_d;

  logic             accept, commit, ok, out_free, load_out, multi_go;
  logic [5:0]       opc_q;
  logic [RIW-1:0]   d_idx_q, a_idx_q, b_idx_q;
  logic [W-1:0]     rd_a_q, rd_b_q, rd_x_q, stk_rd_q;
  logic             rd_a_v_q, rd_b_v_q, rd_x_v_q;
  logic [W-1:0]     op_a, op_b, op_x;
  logic [W-1:0]     pc_q, lr_q, sp_q, da_q;
  logic             fn_q, fz_q, fc_q, fv_q, halt_q;
  logic [1:0]       err_q;
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [W-1:0]     rf_mem [NUM_REGS];
  logic [W-1:0]     stk_mem [STACK_DEPTH];

  // Shared iterative unit
  logic [W-1:0]     hi_q, lo_q, opb_q, hi_d, lo_d;
  logic             neg_q, found_q, found_d;
  logic [CLZW-1:0]  clz_q, clz_d;
  logic [SHW-1:0]   step_q;

  logic             m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // Execute results
  logic [W-1:0]     res, wb_val, pc_b, pc_n, lr_n, sp_n, da_n, xe, stk_wdata;
  logic [SIW-1:0]   stk_waddr;
  logic             wr_d, rf_we, stk_we, br, halt_c;
  logic             nf, zf, cf, vf;
  logic [1:0]       err_c;

  logic [5:0]       in_opc;
  logic [W-1:0]     in_data;
  logic [RIW-1:0]   in_d, in_a, in_b;

  assign in_opc  = s_axis_tdata[OPC_LSB +: 6];
  assign in_data = s_axis_tdata[DATA_LSB +: W];
  assign in_d    = reg_idx(s_axis_tdata[DST_LSB +: 5]);
  assign in_a    = reg_idx(s_axis_tdata[SRCA_LSB +: 5]);
  assign in_b    = reg_idx(s_axis_tdata[SRCB_LSB +: 5]);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Register file: read a and b on acceptance, d in the cycle after, in the operand-read state
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[d_idx_q] <= wb_val;
    end
    if (accept) begin
      rd_a_q   <= rf_mem[in_a];
      rd_b_q   <= rf_mem[in_b];
      rd_a_v_q <= rf_vld_q[in_a];
      rd_b_v_q <= rf_vld_q[in_b];
    end
    if (state_q == ST_RD) begin
      rd_x_q   <= rf_mem[d_idx_q];
      rd_x_v_q <= rf_vld_q[d_idx_q];
    end
  end

  // Stack store: top entry read during the operand cycle
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (state_q == ST_RD) begin
      stk_rd_q <= stk_mem[sp_q[SIW-1:0]];
    end
  end

  // Operand select: special registers live in flops
  function automatic logic [W-1:0] pick(input logic [RIW-1:0] idx, input logic [W-1:0] m,
                                        input logic v, input logic [W-1:0] pc,
                                        input logic [W-1:0] lr, input logic [W-1:0] sp,
                                        input logic [W-1:0] da);
    logic [W-1:0] r;
    case (idx)
      R_DA:    r = da;
      R_PC:    r = pc;
      R_LR:    r = lr;
      R_SP:    r = sp;
      default: r = v ? m : '0;
    endcase
    return r;
  endfunction

  assign op_a = pick(a_idx_q, rd_a_q, rd_a_v_q, pc_q, lr_q, sp_q, da_q);
  assign op_b = pick(b_idx_q, rd_b_q, rd_b_v_q, pc_q, lr_q, sp_q, da_q);
  assign op_x = pick(d_idx_q, rd_x_q, rd_x_v_q, pc_q, lr_q, sp_q, da_q);

  // Execute and write-back values
  always_comb begin
    logic [W:0]     s;
    logic [2*W-1:0] rot;
    logic           cin;
    s         = '0;
    rot       = '0;
    cin       = 1'b0;
    res       = '0;
    wr_d      = 1'b0;
    {nf, zf, cf, vf} = {fn_q, fz_q, fc_q, fv_q};
    err_c     = ERR_NONE;
    halt_c    = 1'b0;
    br        = 1'b0;
    xe        = op_x;
    multi_go  = 1'b0;
    lr_n      = lr_q;
    sp_n      = sp_q;
    da_n      = da_q;
    pc_b      = pc_q;
    stk_we    = 1'b0;
    stk_wdata = op_x;
    stk_waddr = SIW'(sp_q + W'(1));
    rf_we     = 1'b0;
    if (state_q == ST_FIN) begin
      case (opc_q)
        OP_MUL, OP_DIV: begin
          res = lo_q; wr_d = 1'b1;
        end
        OP_MLS, OP_DIVS: begin
          res = lo_q; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(lo_q);
        end
        OP_MULS: begin
          res = lo_q; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(lo_q);
          cf = |hi_q;
        end
        OP_DVS: begin
          res = neg_q ? (W'(0) - lo_q) : lo_q;
          wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res);
        end
        OP_CLZ: begin
          res = W'(clz_q); wr_d = 1'b1;
        end
        OP_ROR: begin
          rot = {op_a, op_a} >> hi_q[SHW-1:0];
          res = rot[W-1:0]; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res);
          cf = res[W-1];
        end
        default: ;
      endcase
    end else begin
      case (opc_q)
        OP_EXT: halt_c = 1'b1;
        OP_ASR: begin
          if (op_b >= W_C) res = {W{op_a[W-1]}};
          else res = $signed(op_a) >>> op_b[SHW-1:0];
          wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res);
        end
        OP_MOV: begin res = op_a; wr_d = 1'b1; end
        OP_ADD: begin res = op_a + op_b; wr_d = 1'b1; end
        OP_ADDS, OP_ADC: begin
          cin = (opc_q == OP_ADC) && fc_q;
          s = {1'b0, op_a} + {1'b0, op_b} + (W + 1)'(cin);
          res = s[W-1:0]; wr_d = 1'b1;
          nf = res[W-1]; zf = (res == '0); cf = s[W];
          vf = (op_a[W-1] ^ res[W-1]) & (op_b[W-1] ^ res[W-1]);
        end
        OP_AND: begin res = op_a & op_b; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); end
        OP_BIC: begin res = op_a & ~op_b; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); end
        OP_EOR: begin res = op_a ^ op_b; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); end
        OP_ORR: begin res = op_a | op_b; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); end
        OP_NOT: begin res = ~op_a; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); end
        OP_CLZ, OP_MUL, OP_MLS, OP_MULS: multi_go = 1'b1;
        OP_ROR: begin
          // power-of-two width: the low amount bits are the amount modulo the width
          if (W_POW2) begin
            rot = {op_a, op_a} >> op_b[SHW-1:0];
            res = rot[W-1:0]; wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res);
            cf = res[W-1];
          end else begin
            multi_go = 1'b1;
          end
        end
        OP_DIV, OP_DVS, OP_DIVS: begin
          if (op_b == '0) err_c = ERR_DIV0;
          else multi_go = 1'b1;
        end
        OP_CMN: begin
          s = {1'b0, op_x} + {1'b0, op_a};
          res = s[W-1:0];
          nf = res[W-1]; zf = (res == '0); cf = s[W];
          vf = (op_x[W-1] ^ res[W-1]) & (op_a[W-1] ^ res[W-1]);
        end
        OP_SUB: begin res = op_a - op_b; wr_d = 1'b1; end
        OP_SUBS, OP_SBC: begin
          cin = (opc_q == OP_SBC) && !fc_q;
          s = {1'b0, op_a} - {1'b0, op_b} - (W + 1)'(cin);
          res = s[W-1:0]; wr_d = 1'b1;
          nf = res[W-1]; zf = (res == '0); cf = !s[W];
          vf = (op_a[W-1] ^ op_b[W-1]) & (op_a[W-1] ^ res[W-1]);
        end
        OP_CMP: begin
          s = {1'b0, op_x} - {1'b0, op_a};
          res = s[W-1:0];
          nf = res[W-1]; zf = (res == '0); cf = !s[W];
          vf = (op_x[W-1] ^ op_a[W-1]) & (op_x[W-1] ^ res[W-1]);
        end
        OP_LSL: begin
          res = (op_b >= W_C) ? '0 : (op_a << op_b[SHW-1:0]);
          wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res);
        end
        OP_LSR: begin
          res = (op_b >= W_C) ? '0 : (op_a >> op_b[SHW-1:0]);
          wr_d = 1'b1; {nf, zf, cf, vf} = lflags(res); nf = 1'b0;
        end
        OP_PUSH: begin
          if (CMPW'(sp_q) >= DEPTH_M1) err_c = ERR_OVF;
          else stk_we = 1'b1;
        end
        OP_POP: begin
          if (sp_q == '0) err_c = ERR_UNF;
          else if (CMPW'(sp_q) >= DEPTH_C) err_c = ERR_OVF;
          else begin res = stk_rd_q; wr_d = 1'b1; end
        end
        OP_BL, OP_B: br = 1'b1;
        OP_BEQ:  br = fz_q;
        OP_BNEQ: br = !fz_q;
        OP_BLEQ: br = fn_q || fz_q;
        OP_BGEQ: br = !fn_q || fz_q;
        OP_BLES: br = fn_q;
        OP_BGRE: br = !fn_q && !fz_q;
        OP_TST: {nf, zf, cf, vf} = lflags(op_a & op_b);
        OP_TEQ: {nf, zf, cf, vf} = lflags(op_a ^ op_b);
        OP_RET, OP_NOP: ;
        default: ;
      endcase
    end

    // Destination write, special registers go to their flops
    wb_val = res;
    if (wr_d && err_c == ERR_NONE) begin
      case (d_idx_q)
        R_DA:    da_n = res;
        R_PC:    pc_b = res;
        R_LR:    lr_n = res;
        R_SP:    sp_n = res;
        default: rf_we = commit;
      endcase
    end

    // Side updates that follow the destination write
    if (state_q != ST_FIN) begin
      case (opc_q)
        OP_PUSH: begin
          sp_n = sp_q + W'(1);
          if (d_idx_q == R_SP) stk_wdata = sp_q + W'(1);
        end
        OP_POP: sp_n = ((d_idx_q == R_SP) ? res : sp_q) - W'(1);
        OP_BL: begin
          lr_n = pc_q;
          if (d_idx_q == R_LR) xe = pc_q;
        end
        OP_RET: pc_b = lr_q;
        default: ;
      endcase
    end
    stk_we = stk_we && commit;

    if (err_c != ERR_NONE) pc_n = pc_q;
    else if (br)          pc_n = pc_q + xe;
    else                  pc_n = pc_b + W'(1);
  end

  // Iterative unit: shift-add multiply, restoring divide, leading-zero scan
  always_comb begin
    logic [W:0] t;
    t       = '0;
    hi_d    = hi_q;
    lo_d    = lo_q;
    clz_d   = clz_q;
    found_d = found_q;
    case (opc_q)
      OP_MUL, OP_MLS, OP_MULS: begin
        t    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opb_q} : '0);
        hi_d = t[W:1];
        lo_d = {t[0], lo_q[W-1:1]};
      end
      OP_CLZ: begin
        if (!found_q && !lo_q[W-1]) clz_d = clz_q + CLZW'(1);
        found_d = found_q | lo_q[W-1];
        lo_d    = lo_q << 1;
      end
      default: begin
        t = {hi_q, lo_q[W-1]};
        if (t >= {1'b0, opb_q}) begin
          t    = t - {1'b0, opb_q};
          lo_d = {lo_q[W-2:0], 1'b1};
        end else begin
          lo_d = {lo_q[W-2:0], 1'b0};
        end
        hi_d = t[W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EX && multi_go) begin
      step_q  <= SHW'(WORD_BITS - 1);
      hi_q    <= '0;
      clz_q   <= '0;
      found_q <= 1'b0;
      neg_q   <= 1'b0;
      case (opc_q)
        OP_MUL, OP_MLS, OP_MULS: begin
          lo_q  <= op_b;
          opb_q <= op_a;
        end
        OP_DVS: begin
          lo_q  <= op_a[W-1] ? (W'(0) - op_a) : op_a;
          opb_q <= op_b[W-1] ? (W'(0) - op_b) : op_b;
          neg_q <= op_a[W-1] ^ op_b[W-1];
        end
        OP_ROR: begin
          lo_q  <= op_b;
          opb_q <= W_C;
        end
        default: begin
          lo_q  <= op_a;
          opb_q <= op_b;
        end
      endcase
    end else if (state_q == ST_ITER) begin
      step_q  <= step_q - SHW'(1);
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      clz_q   <= clz_d;
      found_q <= found_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = (s_axis_tuser == KIND_START) ? ST_OUT : ST_RD;
      ST_RD:   state_d = ST_EX;
      ST_EX:   state_d = multi_go ? ST_ITER : ST_OUT;
      ST_ITER: if (step_q == '0) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    commit        = (state_q == ST_EX && !multi_go) || (state_q == ST_FIN);
    ok            = commit && (err_c == ERR_NONE);
    load_out      = (state_q == ST_OUT) && out_free;
  end

  // Result word for the output register
  always_comb begin
    m_data_d = '0;
    m_data_d[PC_LSB +: 64]       = 64'(pc_q);
    m_data_d[FN_BIT]             = fn_q;
    m_data_d[FZ_BIT]             = fz_q;
    m_data_d[FC_BIT]             = fc_q;
    m_data_d[FV_BIT]             = fv_q;
    m_data_d[HALT_BIT]           = halt_q;
    m_data_d[ERR_LSB +: 2]       = err_q;
  end

  // Item fields held for the whole execution
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opc_q   <= in_opc;
      d_idx_q <= in_d;
      a_idx_q <= in_a;
      b_idx_q <= in_b;
    end
    if (load_out) begin
      m_data_q <= m_data_d;
    end
  end

  // Architectural state and handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      lr_q      <= '0;
      sp_q      <= '0;
      da_q      <= '0;
      fn_q      <= 1'b0;
      fz_q      <= 1'b0;
      fc_q      <= 1'b0;
      fv_q      <= 1'b0;
      halt_q    <= 1'b0;
      err_q     <= ERR_NONE;
      rf_vld_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        halt_q <= 1'b0;
        err_q  <= ERR_NONE;
        if (s_axis_tuser == KIND_START) pc_q <= in_data;
        else da_q <= in_data;
      end
      if (commit) begin
        pc_q   <= pc_n;
        halt_q <= halt_c && (err_c == ERR_NONE);
        err_q  <= err_c;
      end
      if (ok) begin
        lr_q <= lr_n;
        sp_q <= sp_n;
        da_q <= da_n;
        {fn_q, fz_q, fc_q, fv_q} <= {nf, zf, cf, vf};
      end
      if (rf_we) begin
        rf_vld_q[d_idx_q] <= 1'b1;
      end
      if (load_out) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
